// ===== hdl/ted_pkg.sv =====
// Shared types and constants of the typed event deque.
`default_nettype none

package ted_pkg;

    localparam int unsigned HANDLE_W = 16;
    localparam int unsigned TYPE_W   = 8;
    localparam int unsigned TALLY_W  = 7;
    localparam int unsigned ENTRY_W  = HANDLE_W + TYPE_W;

    typedef enum logic [2:0] {
        REQ_POST_BACK  = 3'd0,
        REQ_POST_FRONT = 3'd1,
        REQ_FLUSH_POST = 3'd2,
        REQ_POP        = 3'd3,
        REQ_PEEK       = 3'd4,
        REQ_POP_MATCH  = 3'd5,
        REQ_POP_NONE   = 3'd6,
        REQ_FLUSH      = 3'd7
    } req_code_t;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

    typedef struct packed {
        logic                popped_valid;
        logic [HANDLE_W-1:0] popped_handle;
        logic [TYPE_W-1:0]   popped_type;
        logic                head_valid;
        logic [TYPE_W-1:0]   head_type;
        logic                type_mismatch;
        logic                signal_pending;
        logic                post_rejected;
        logic [TALLY_W-1:0]  dropped_count;
        logic [TALLY_W-1:0]  occupancy;
    } result_t;

endpackage

`default_nettype wire

// ===== hdl/ted_req_if.sv =====
// Request channel of the typed event deque.
`default_nettype none

interface ted_req_if import ted_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [2:0]          req_type;
    logic [HANDLE_W-1:0] event_handle;
    logic [TYPE_W-1:0]   event_type;
    logic [TYPE_W-1:0]   match_type_a;
    logic [TYPE_W-1:0]   match_type_b;

    modport source (
        output valid,
        output req_type,
        output event_handle,
        output event_type,
        output match_type_a,
        output match_type_b,
        input  ready
    );

    modport sink (
        input  valid,
        input  req_type,
        input  event_handle,
        input  event_type,
        input  match_type_a,
        input  match_type_b,
        output ready
    );

endinterface

`default_nettype wire

// ===== hdl/ted_rsp_if.sv =====
// Result channel of the typed event deque.
`default_nettype none

interface ted_rsp_if import ted_pkg::*; ();

    logic                valid;
    logic                ready;
    logic                popped_valid;
    logic [HANDLE_W-1:0] popped_handle;
    logic [TYPE_W-1:0]   popped_type;
    logic                head_valid;
    logic [TYPE_W-1:0]   head_type;
    logic                type_mismatch;
    logic                signal_pending;
    logic                post_rejected;
    logic [TALLY_W-1:0]  dropped_count;
    logic [TALLY_W-1:0]  occupancy;

    modport source (
        output valid,
        output popped_valid,
        output popped_handle,
        output popped_type,
        output head_valid,
        output head_type,
        output type_mismatch,
        output signal_pending,
        output post_rejected,
        output dropped_count,
        output occupancy,
        input  ready
    );

    modport sink (
        input  valid,
        input  popped_valid,
        input  popped_handle,
        input  popped_type,
        input  head_valid,
        input  head_type,
        input  type_mismatch,
        input  signal_pending,
        input  post_rejected,
        input  dropped_count,
        input  occupancy,
        output ready
    );

endinterface

`default_nettype wire

// ===== hdl/typed_event_deque.sv =====
// Typed event deque: ring of handle/type entries with conditional pops.
//
// Posts (back, front, flush-then-post) and flushes finish in the cycle they
// are accepted; the result word lands in the output register on the next edge.
// Pop, peek, pop-if-match and pop-if-neither read the head entry from the
// entry memory, whose read data is registered, and finish in ST_READ, during
// which no new request is taken. A request is accepted whenever no head read
// is in flight and the output register is empty or being drained, so the rate
// is one word per cycle for posts and flushes while rsp.ready holds, and a
// head lookup blocks new requests until its word is loaded. Front and back
// posts to a full queue are rejected and flagged; the memory needs no clearing.
`default_nettype none

module typed_event_deque import ted_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = 64
) (
    input  wire logic clk,
    input  wire logic rst_n,
    ted_req_if.sink   req,
    ted_rsp_if.source rsp
);

    localparam int unsigned IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned SUM_W = CNT_W + 1;

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    head_reg, head_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                wake_reg, wake_next;
    req_code_t           pend_code_reg, pend_code_next;
    logic [TYPE_W-1:0]   pend_ta_reg, pend_ta_next;
    logic [TYPE_W-1:0]   pend_tb_reg, pend_tb_next;
    logic                out_valid_reg, out_valid_next;
    result_t             out_data_reg, out_data_next;

    logic                accept;
    logic                load_out;
    result_t             res;
    req_code_t           code;
    logic                full;
    logic                nonempty;
    logic [SUM_W-1:0]    tail_sum;
    logic [SUM_W-1:0]    tail_wrap;
    logic [IDX_W-1:0]    tail_idx;
    logic [IDX_W-1:0]    head_prev;
    logic [IDX_W-1:0]    head_succ;
    logic [31:0]         count_wide;
    logic [31:0]         count_next_wide;

    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [ENTRY_W-1:0]  wr_data;
    logic                rd_en;
    logic [ENTRY_W-1:0]  rd_data;
    logic [TYPE_W-1:0]   rd_type;

    ted_ram #(
        .DEPTH  (QUEUE_DEPTH),
        .ADDR_W (IDX_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (head_reg),
        .rd_data (rd_data)
    );

    assign req.ready = (state_reg == ST_IDLE) && (!out_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;
    assign code      = req_code_t'(req.req_type);

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign nonempty  = (count_reg != '0);
    assign tail_sum  = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign tail_wrap = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ? tail_sum - SUM_W'(QUEUE_DEPTH)
                                                          : tail_sum;
    assign tail_idx  = tail_wrap[IDX_W-1:0];
    assign head_prev = (head_reg == '0) ? IDX_W'(QUEUE_DEPTH - 1) : head_reg - 1'b1;
    assign head_succ = (head_reg == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign rd_type   = rd_data[TYPE_W-1:0];

    assign count_wide      = 32'(count_reg);
    assign count_next_wide = 32'(count_next);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (code == REQ_POP || code == REQ_PEEK ||
                               code == REQ_POP_MATCH || code == REQ_POP_NONE))
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and result
    always_comb
    begin
        head_next      = head_reg;
        count_next     = count_reg;
        wake_next      = wake_reg;
        pend_code_next = pend_code_reg;
        pend_ta_next   = pend_ta_reg;
        pend_tb_next   = pend_tb_reg;
        wr_en          = 1'b0;
        wr_addr        = head_reg;
        wr_data        = {req.event_handle, req.event_type};
        rd_en          = 1'b0;
        load_out       = 1'b0;
        res            = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (code)
                        REQ_POST_BACK:
                        begin
                            load_out = 1'b1;
                            if (full)
                            begin
                                res.post_rejected = 1'b1;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = tail_idx;
                                count_next = count_reg + 1'b1;
                                if (!nonempty)
                                begin
                                    wake_next = 1'b1;
                                end
                            end
                        end
                        REQ_POST_FRONT:
                        begin
                            load_out = 1'b1;
                            if (full)
                            begin
                                res.post_rejected = 1'b1;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = head_prev;
                                head_next  = head_prev;
                                count_next = count_reg + 1'b1;
                                wake_next  = 1'b1;
                            end
                        end
                        REQ_FLUSH_POST:
                        begin
                            load_out          = 1'b1;
                            res.dropped_count = count_wide[TALLY_W-1:0];
                            wr_en             = 1'b1;
                            count_next        = CNT_W'(1);
                            wake_next         = 1'b1;
                        end
                        REQ_FLUSH:
                        begin
                            load_out          = 1'b1;
                            res.dropped_count = count_wide[TALLY_W-1:0];
                            count_next        = '0;
                            wake_next         = 1'b0;
                        end
                        default:
                        begin
                            // head lookups: fetch the head entry first
                            rd_en          = 1'b1;
                            pend_code_next = code;
                            pend_ta_next   = req.match_type_a;
                            pend_tb_next   = req.match_type_b;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                load_out = 1'b1;
                case (pend_code_reg)
                    REQ_POP:
                    begin
                        if (nonempty)
                        begin
                            res.popped_valid = 1'b1;
                            if (count_reg == CNT_W'(1))
                            begin
                                wake_next = 1'b0;
                            end
                        end
                        else
                        begin
                            wake_next = 1'b0;
                        end
                    end
                    REQ_PEEK:
                    begin
                        wake_next = 1'b0;
                        if (nonempty)
                        begin
                            res.head_valid = 1'b1;
                            res.head_type  = rd_type;
                        end
                    end
                    REQ_POP_MATCH:
                    begin
                        wake_next = 1'b0;
                        if (nonempty)
                        begin
                            if (rd_type == pend_ta_reg)
                            begin
                                res.popped_valid = 1'b1;
                            end
                            else
                            begin
                                res.type_mismatch = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        wake_next = 1'b0;
                        if (nonempty && rd_type != pend_ta_reg && rd_type != pend_tb_reg)
                        begin
                            res.popped_valid = 1'b1;
                        end
                    end
                endcase
                if (res.popped_valid)
                begin
                    res.popped_handle = rd_data[ENTRY_W-1:TYPE_W];
                    res.popped_type   = rd_type;
                    head_next         = head_succ;
                    count_next        = count_reg - 1'b1;
                end
            end
            default:
            begin
                load_out = 1'b0;
            end
        endcase

        res.signal_pending = wake_next;
        res.occupancy      = count_next_wide[TALLY_W-1:0];
    end

    // output register
    always_comb
    begin
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_data_next  = res;
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            wake_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            wake_reg      <= wake_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_code_reg <= pend_code_next;
        pend_ta_reg   <= pend_ta_next;
        pend_tb_reg   <= pend_tb_next;
        out_data_reg  <= out_data_next;
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.popped_valid   = out_data_reg.popped_valid;
    assign rsp.popped_handle  = out_data_reg.popped_handle;
    assign rsp.popped_type    = out_data_reg.popped_type;
    assign rsp.head_valid     = out_data_reg.head_valid;
    assign rsp.head_type      = out_data_reg.head_type;
    assign rsp.type_mismatch  = out_data_reg.type_mismatch;
    assign rsp.signal_pending = out_data_reg.signal_pending;
    assign rsp.post_rejected  = out_data_reg.post_rejected;
    assign rsp.dropped_count  = out_data_reg.dropped_count;
    assign rsp.occupancy      = out_data_reg.occupancy;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    a_no_accept_in_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_READ |-> !req.ready)
        else $error("request taken while head read in flight");

    a_read_yields_word: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_READ |=> out_valid_reg)
        else $error("head read produced no result word");

    a_empty_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_READ && count_reg == '0 |=> !out_data_reg.popped_valid)
        else $error("pop reported on an empty queue");

endmodule

`default_nettype wire

// ===== hdl/ted_ram.sv =====
// Single-port-write, single-port-read entry memory with registered read data.
`default_nettype none

module ted_ram import ted_pkg::*; #(
    parameter int unsigned DEPTH  = 64,
    parameter int unsigned ADDR_W = 6
) (
    input  wire logic               clk,
    input  wire logic               wr_en,
    input  wire logic [ADDR_W-1:0]  wr_addr,
    input  wire logic [ENTRY_W-1:0] wr_data,
    input  wire logic               rd_en,
    input  wire logic [ADDR_W-1:0]  rd_addr,
    output logic      [ENTRY_W-1:0] rd_data
);

    logic [ENTRY_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire
